// ----- design/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the averager modules. Each macro expects a
// clock named clk and a synchronous reset named rst in the using scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every edge outside reset
`define HRIA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define HRIA_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define HRIA_ASSERT(lbl, prop, msg)

`define HRIA_NEVER(lbl, cond, msg)

`endif

`endif

// ----- design/hria_pkg.sv -----
// ---------------------------------------------------------------------------
// hria_pkg
// Types and constants for the heart-rate interval averager.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package hria_pkg;

  localparam int RING_DEPTH       = 4;
  localparam int SLOT_W           = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int BPM_W            = 8;
  localparam int SUM_W            = BPM_W + SLOT_W;

  localparam int RATE_NUMERATOR   = 60000;
  localparam int RATE_UPPER_BOUND = 255;
  localparam int RATE_LOWER_BOUND = 20;

  // exact window of intervals whose rate lies strictly inside the bounds
  localparam int INTERVAL_MIN     = RATE_NUMERATOR / RATE_UPPER_BOUND + 1;
  localparam int INTERVAL_MAX     = (RATE_NUMERATOR - 1) / RATE_LOWER_BOUND;
  localparam int INTERVAL_W       = $clog2(INTERVAL_MAX + 1);

  localparam int NUM_W            = $clog2(RATE_NUMERATOR + 1);
  localparam int CNT_W            = $clog2(NUM_W);

  localparam int TIME_W           = 32;
  localparam int IR_W             = 18;
  localparam int CFG_W            = 32;
  localparam int CFG_IDX_W        = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FINGER_THRESHOLD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_LOW_BPM      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_HIGH_BPM     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CRITICAL_LOW_BPM    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CRITICAL_HOLDOFF_MS = 3'd4;

  localparam logic [IR_W-1:0]   FINGER_THRESHOLD_RST    = 18'd50000;
  localparam logic [BPM_W-1:0]  NORMAL_LOW_BPM_RST      = 8'd60;
  localparam logic [BPM_W-1:0]  NORMAL_HIGH_BPM_RST     = 8'd100;
  localparam logic [BPM_W-1:0]  CRITICAL_LOW_BPM_RST    = 8'd50;
  localparam logic [TIME_W-1:0] CRITICAL_HOLDOFF_MS_RST = 32'd30000;

  typedef struct packed {
    logic [TIME_W-1:0] time_ms;
    logic [IR_W-1:0]   ir_level;
    logic              beat_seen;
  } in_word_t;

  typedef struct packed {
    logic [BPM_W-1:0] average_bpm;
    logic             finger_present;
    logic             rate_alert;
    logic             critical_pulse;
  } out_word_t;

  typedef struct packed {
    logic load;      // capture input word, measure interval
    logic div_step;  // one restoring divide step
    logic update;    // ring write and average update
    logic emit;      // flags into output register
  } hria_cmd_t;

  typedef struct packed {
    logic need_div;  // beat with interval inside the window
    logic div_last;  // final divide step in progress
    logic out_free;  // output register can take a word
  } hria_status_t;

endpackage

// ----- design/hria_ctrl.sv -----
// ---------------------------------------------------------------------------
// hria_ctrl
// Sequencer: accept a word, run the divider, update the ring, emit flags.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hria_ctrl
  import hria_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  hria_status_t status,
  output hria_cmd_t    cmd
);

  typedef enum logic [1:0] {
    IDLE,
    DIVIDE,
    UPDATE,
    EMIT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_valid) state <= DIVIDE;
        end
        DIVIDE: begin
          if (!status.need_div || status.div_last) state <= UPDATE;
        end
        UPDATE: begin
          state <= EMIT;
        end
        EMIT: begin
          if (status.out_free) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign in_stall     = (state != IDLE);
  assign cmd.load     = (state == IDLE) && in_valid;
  assign cmd.div_step = (state == DIVIDE) && status.need_div;
  assign cmd.update   = (state == UPDATE);
  assign cmd.emit     = (state == EMIT) && status.out_free;

  `HRIA_ASSERT(a_load_to_divide, cmd.load |=> state == DIVIDE, "load did not start divide")
  `HRIA_ASSERT(a_last_to_update, cmd.div_step && status.div_last |=> state == UPDATE,
               "divider end missed")
  `HRIA_ASSERT(a_update_to_emit, cmd.update |=> state == EMIT, "update not followed by emit")

endmodule

// ----- design/hria_dp.sv -----
// ---------------------------------------------------------------------------
// hria_dp
// Datapath: config registers, interval capture, serial divider, rate ring,
// averaging and alert flags with output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hria_dp
  import hria_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  in_word_t             in_data,
  input  hria_cmd_t            cmd,
  output hria_status_t         status,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_data
);

  // configuration
  logic [IR_W-1:0]   finger_threshold;
  logic [BPM_W-1:0]  normal_low_bpm;
  logic [BPM_W-1:0]  normal_high_bpm;
  logic [BPM_W-1:0]  critical_low_bpm;
  logic [TIME_W-1:0] critical_holdoff_ms;

  // per-word state
  in_word_t            cur;
  logic                need_div;
  logic [INTERVAL_W-1:0] divisor;
  logic [INTERVAL_W:0] rem;
  logic [NUM_W-1:0]    quo;
  logic [CNT_W-1:0]    div_cnt;
  logic                finger;

  // persistent state
  logic [TIME_W-1:0]   previous_beat_time;
  logic [TIME_W-1:0]   last_critical_time;
  logic [BPM_W-1:0]    rate_ring [RING_DEPTH];
  logic [SLOT_W-1:0]   ring_slot;
  logic [SUM_W-1:0]    ring_sum;
  logic [BPM_W-1:0]    held_average;

  logic [TIME_W-1:0]   interval;
  logic                in_window;
  logic [INTERVAL_W:0] shifted;
  logic                fits;
  logic [BPM_W-1:0]    rate;
  logic [SUM_W-1:0]    sum_next;
  logic [BPM_W-1:0]    avg_next;
  logic                finger_now;
  logic [TIME_W-1:0]   since_critical;
  logic                alert;
  logic                pulse;

  always_ff @(posedge clk) begin
    if (rst) begin
      finger_threshold    <= FINGER_THRESHOLD_RST;
      normal_low_bpm      <= NORMAL_LOW_BPM_RST;
      normal_high_bpm     <= NORMAL_HIGH_BPM_RST;
      critical_low_bpm    <= CRITICAL_LOW_BPM_RST;
      critical_holdoff_ms <= CRITICAL_HOLDOFF_MS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FINGER_THRESHOLD:    finger_threshold    <= cfg_data[IR_W-1:0];
        REG_NORMAL_LOW_BPM:      normal_low_bpm      <= cfg_data[BPM_W-1:0];
        REG_NORMAL_HIGH_BPM:     normal_high_bpm     <= cfg_data[BPM_W-1:0];
        REG_CRITICAL_LOW_BPM:    critical_low_bpm    <= cfg_data[BPM_W-1:0];
        REG_CRITICAL_HOLDOFF_MS: critical_holdoff_ms <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // interval window check at capture
  assign interval  = in_data.time_ms - previous_beat_time;
  assign in_window = (interval >= TIME_W'(INTERVAL_MIN)) &&
                     (interval <= TIME_W'(INTERVAL_MAX));

  // restoring divide: numerator bits shift out of quo as quotient bits shift in
  assign shifted = {rem[INTERVAL_W-1:0], quo[NUM_W-1]};
  assign fits    = (shifted >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur      <= in_data;
      need_div <= in_data.beat_seen && in_window;
      divisor  <= interval[INTERVAL_W-1:0];
      rem      <= '0;
      quo      <= NUM_W'(RATE_NUMERATOR);
      div_cnt  <= CNT_W'(NUM_W - 1);
    end else if (cmd.div_step) begin
      rem     <= fits ? (shifted - {1'b0, divisor}) : shifted;
      quo     <= {quo[NUM_W-2:0], fits};
      div_cnt <= div_cnt - 1'b1;
    end
  end

  assign rate       = quo[BPM_W-1:0];
  assign sum_next   = ring_sum - SUM_W'(rate_ring[ring_slot]) + SUM_W'(rate);
  assign avg_next   = BPM_W'(sum_next / RING_DEPTH);
  assign finger_now = (cur.ir_level >= finger_threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_beat_time <= '0;
      ring_slot          <= '0;
      ring_sum           <= '0;
      held_average       <= '0;
      for (int i = 0; i < RING_DEPTH; i++) rate_ring[i] <= '0;
    end else begin
      if (cmd.load && in_data.beat_seen) previous_beat_time <= in_data.time_ms;
      if (cmd.update) begin
        if (need_div) begin
          rate_ring[ring_slot] <= rate;
          ring_sum             <= sum_next;
          ring_slot            <= (ring_slot == SLOT_W'(RING_DEPTH - 1)) ?
                                  '0 : ring_slot + 1'b1;
        end
        // no finger forces zero; the ring is still updated
        if (!finger_now)   held_average <= '0;
        else if (need_div) held_average <= avg_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) finger <= finger_now;
  end

  assign since_critical = cur.time_ms - last_critical_time;
  assign alert = (held_average != '0) &&
                 ((held_average < normal_low_bpm) || (held_average > normal_high_bpm));
  assign pulse = finger && (held_average != '0) && (held_average < critical_low_bpm) &&
                 (since_critical >= critical_holdoff_ms);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_critical_time <= '0;
      out_valid          <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
        if (pulse) last_critical_time <= cur.time_ms;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.average_bpm    <= held_average;
      out_data.finger_present <= finger;
      out_data.rate_alert     <= alert;
      out_data.critical_pulse <= pulse;
    end
  end

  assign status.need_div = need_div;
  assign status.div_last = (div_cnt == '0);
  assign status.out_free = !out_valid || !out_stall;

  `HRIA_ASSERT(a_no_finger_zero, cmd.update && !finger_now |=> held_average == '0,
               "average not cleared without finger")
  `HRIA_ASSERT(a_pulse_stamps, cmd.emit && pulse |=> last_critical_time == $past(cur.time_ms),
               "critical time not stamped")
  `HRIA_NEVER(a_word_no_finger,
              out_valid && !out_data.finger_present &&
              (out_data.average_bpm != '0 || out_data.critical_pulse),
              "nonzero average or pulse without finger")

endmodule

// ----- design/heart_rate_interval_averager.sv -----
// ---------------------------------------------------------------------------
// heart_rate_interval_averager
// Beat interval to rate by serial division, 4-entry rate ring mean,
// finger detect, out-of-band alert and holdoff-limited critical pulse.
// ---------------------------------------------------------------------------
//   channel  | signals                        | word
//   ---------+--------------------------------+---------------------------
//   in       | in_valid, in_stall, in_data    | time_ms, ir_level, beat_seen
//   out      | out_valid, out_stall, out_data | average_bpm, finger_present,
//            |                                | rate_alert, critical_pulse
//   cfg      | cfg_we, cfg_index, cfg_data    | five registers, write only
//
// One word at a time; a beat that falls in the valid interval window also
// runs the 16 steps of the radix-2 divider.
// Synchronous reset restores register defaults and clears the ring.
// A result waits in the output register; the next sample is still taken,
// and only the emit step waits while out_stall holds the previous word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module heart_rate_interval_averager
  import hria_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_data
);

  hria_cmd_t    cmd;
  hria_status_t status;

  hria_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  hria_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- test/hria_result_checker.sv -----
// ---------------------------------------------------------------------------
// hria_result_checker
// Watches the sample, result and register channels of the heart-rate
// interval averager. It keeps its own model of the beat interval, the rate
// ring and the critical holdoff timer. It predicts one result word for each
// accepted sample, compares result words in order and counts mismatches.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hria_result_checker
  import hria_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_word_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_word_t            out_data,
  output int                   mismatches,
  output int                   pending,
  output int                   checked,
  output int                   pulses,
  output int                   alerts
);

  localparam int REPORT_LIMIT = 10;

  // register copies
  logic [IR_W-1:0]   thr;
  logic [BPM_W-1:0]  band_low;
  logic [BPM_W-1:0]  band_high;
  logic [BPM_W-1:0]  crit_low;
  logic [TIME_W-1:0] holdoff;

  // model state
  logic [TIME_W-1:0] beat_time;
  logic [BPM_W-1:0]  rates [RING_DEPTH];
  logic [SLOT_W-1:0] slot;
  logic [BPM_W-1:0]  avg_hold;
  logic [TIME_W-1:0] crit_time;

  out_word_t expected_words [$];

  function automatic out_word_t predict_sample(in_word_t w);
    logic [TIME_W-1:0] gap;
    logic [TIME_W-1:0] since_pulse;
    logic [63:0]       span;
    logic [63:0]       rate;
    logic [SUM_W-1:0]  total;
    logic              finger;
    out_word_t         r;
    if (w.beat_seen) begin
      gap       = w.time_ms - beat_time;
      beat_time = w.time_ms;
      span      = 64'(gap);
      // exact window test by cross multiplication, no division needed
      if (span != 0 && span * RATE_UPPER_BOUND > RATE_NUMERATOR &&
          span * RATE_LOWER_BOUND < RATE_NUMERATOR) begin
        rate        = RATE_NUMERATOR / span;
        rates[slot] = rate[BPM_W-1:0];
        slot        = (slot == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot + 1'b1;
        total       = '0;
        for (int i = 0; i < RING_DEPTH; i++) total = total + rates[i];
        avg_hold = BPM_W'(total / RING_DEPTH);
      end
    end
    finger = (w.ir_level >= thr);
    // no finger zeroes the held average, ring stays
    if (!finger) avg_hold = '0;
    r.average_bpm    = avg_hold;
    r.finger_present = finger;
    r.rate_alert     = (avg_hold != 0) && (avg_hold < band_low || avg_hold > band_high);
    since_pulse      = w.time_ms - crit_time;
    r.critical_pulse = finger && (avg_hold != 0) && (avg_hold < crit_low) &&
                       (since_pulse >= holdoff);
    if (r.critical_pulse) crit_time = w.time_ms;
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      thr       = FINGER_THRESHOLD_RST;
      band_low  = NORMAL_LOW_BPM_RST;
      band_high = NORMAL_HIGH_BPM_RST;
      crit_low  = CRITICAL_LOW_BPM_RST;
      holdoff   = CRITICAL_HOLDOFF_MS_RST;
      beat_time = '0;
      for (int i = 0; i < RING_DEPTH; i++) rates[i] = '0;
      slot      = '0;
      avg_hold  = '0;
      crit_time = '0;
      expected_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FINGER_THRESHOLD:    thr       = cfg_data[IR_W-1:0];
          REG_NORMAL_LOW_BPM:      band_low  = cfg_data[BPM_W-1:0];
          REG_NORMAL_HIGH_BPM:     band_high = cfg_data[BPM_W-1:0];
          REG_CRITICAL_LOW_BPM:    crit_low  = cfg_data[BPM_W-1:0];
          REG_CRITICAL_HOLDOFF_MS: holdoff   = cfg_data[TIME_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: result word with nothing pending: avg=%0d finger=%0b alert=%0b pulse=%0b",
                     $realtime, out_data.average_bpm, out_data.finger_present,
                     out_data.rate_alert, out_data.critical_pulse);
        end else begin
          want = expected_words.pop_front();
          checked++;
          if (out_data.rate_alert === 1'b1) alerts++;
          if (out_data.critical_pulse === 1'b1) pulses++;
          if (out_data.average_bpm !== want.average_bpm ||
              out_data.finger_present !== want.finger_present ||
              out_data.rate_alert !== want.rate_alert ||
              out_data.critical_pulse !== want.critical_pulse) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("%0t: word %0d expected avg=%0d finger=%0b alert=%0b pulse=%0b",
                       $realtime, checked, want.average_bpm, want.finger_present,
                       want.rate_alert, want.critical_pulse,
                       "\n    got avg=%0d finger=%0b alert=%0b pulse=%0b",
                       out_data.average_bpm, out_data.finger_present,
                       out_data.rate_alert, out_data.critical_pulse);
          end
        end
      end
      if (in_valid && !in_stall) expected_words.push_back(predict_sample(in_data));
    end
    pending = expected_words.size();
  end

endmodule

// ----- test/heart_rate_interval_averager_tb.sv -----
// ---------------------------------------------------------------------------
// heart_rate_interval_averager_tb
// Feeds the averager with directed and random optical samples: beats inside,
// on and outside the interval window, finger on and off, timer wrap. Runs
// under five register settings and several idle and stall mixes. Checking is
// done by hria_result_checker, this module only drives and reports.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module heart_rate_interval_averager_tb;
  import hria_pkg::*;

  localparam logic [IR_W-1:0] IR_MAX = '1;
  localparam int SLOW_INTERVAL_MIN   = 1200;  // rates of 50 bpm and below
  localparam int RANDOM_PER_PHASE    = 226;
  localparam int SETTLE_CYCLES       = 25;
  localparam int DRAIN_CYCLES        = 64;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_word_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_data;

  int mismatches;
  int pending;
  int checked;
  int pulses;
  int alerts;

  int                send_idle_pct  = 0;
  int                recv_stall_pct = 0;
  int                samples_sent   = 0;
  logic [IR_W-1:0]   cur_thr        = FINGER_THRESHOLD_RST;
  logic [TIME_W-1:0] now_ms         = '0;
  logic [TIME_W-1:0] last_beat_ms   = '0;

  heart_rate_interval_averager u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  hria_result_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked),
    .pulses     (pulses),
    .alerts     (alerts)
  );

  always #10 clk = ~clk;

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(negedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic drive_sample(input in_word_t w);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic send(input logic [TIME_W-1:0] t, input logic [IR_W-1:0] ir,
                      input logic beat);
    in_word_t w;
    w.time_ms   = t;
    w.ir_level  = ir;
    w.beat_seen = beat;
    drive_sample(w);
  endtask

  // consecutive writes keep cfg_we high; caller lowers it after the last
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  // junk in the bits above each register's width must be dropped
  task automatic load_settings(input logic [IR_W-1:0] thr, input logic [BPM_W-1:0] lo,
                               input logic [BPM_W-1:0] hi, input logic [BPM_W-1:0] crit,
                               input logic [TIME_W-1:0] hold);
    write_reg(REG_FINGER_THRESHOLD, ($urandom() << IR_W) | CFG_W'(thr));
    write_reg(REG_NORMAL_LOW_BPM, ($urandom() << BPM_W) | CFG_W'(lo));
    write_reg(REG_NORMAL_HIGH_BPM, ($urandom() << BPM_W) | CFG_W'(hi));
    write_reg(REG_CRITICAL_LOW_BPM, ($urandom() << BPM_W) | CFG_W'(crit));
    write_reg(REG_CRITICAL_HOLDOFF_MS, CFG_W'(hold));
    for (int k = REG_CRITICAL_HOLDOFF_MS + 1; k < (1 << CFG_IDX_W); k++)
      write_reg(CFG_IDX_W'(k), $urandom());
    cfg_we  <= 1'b0;
    cur_thr = thr;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [IR_W-1:0] pick_ir();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return IR_W'($urandom());
    if (pick < 25 && cur_thr != 0) return IR_W'($urandom_range(cur_thr - 1, 0));
    return IR_W'($urandom_range(IR_MAX, cur_thr));
  endfunction

  function automatic logic [TIME_W-1:0] boundary_gap();
    case ($urandom_range(6))
      0:       return '0;
      1:       return 1;
      2:       return INTERVAL_MIN - 1;
      3:       return INTERVAL_MIN;
      4:       return INTERVAL_MAX;
      5:       return INTERVAL_MAX + 1;
      default: return $urandom();
    endcase
  endfunction

  // mostly a plausible pulse train; a few boundary beats and pure noise
  function automatic in_word_t next_random_sample();
    int       pick;
    in_word_t w;
    pick        = $urandom_range(99);
    w.ir_level  = pick_ir();
    w.beat_seen = 1'b1;
    if (pick < 60) begin
      now_ms      = now_ms + $urandom_range(40, 1);
      w.beat_seen = 1'b0;
    end else if (pick < 85) begin
      if ($urandom_range(1) != 0)
        now_ms = last_beat_ms + $urandom_range(INTERVAL_MAX, SLOW_INTERVAL_MIN);
      else
        now_ms = last_beat_ms + $urandom_range(INTERVAL_MAX, INTERVAL_MIN);
    end else if (pick < 93) begin
      now_ms = last_beat_ms + boundary_gap();
    end else begin
      w.ir_level  = IR_W'($urandom());
      w.beat_seen = 1'($urandom_range(1));
      if (w.beat_seen) now_ms = $urandom();
    end
    w.time_ms = now_ms;
    if (w.beat_seen) last_beat_ms = now_ms;
    return w;
  endfunction

  task automatic run_random(input int count);
    repeat (count) drive_sample(next_random_sample());
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset settings, no idling
    send(32'd0, '0, 1'b0);
    send(32'd1000, IR_MAX, 1'b1);
    send(32'd1000, IR_MAX, 1'b1);                 // same timestamp twice
    send(32'd1235, 18'd60000, 1'b1);              // one below the window
    send(32'd1471, 18'd60000, 1'b1);              // fastest accepted rate
    send(32'd4470, 18'd60000, 1'b1);              // slowest accepted rate
    send(32'd7470, 18'd60000, 1'b1);              // one above the window
    send(32'd8470, FINGER_THRESHOLD_RST - 1'b1, 1'b1);
    send(32'd8480, FINGER_THRESHOLD_RST, 1'b0);
    send(32'd9470, 18'd60000, 1'b1);
    send(32'd40000, 18'd60000, 1'b0);
    send(32'd40001, 18'd60000, 1'b0);
    send(32'd70001, 18'd60000, 1'b0);
    send(32'hFFFF_FF00, 18'd60000, 1'b1);
    send(32'h0000_0300, 18'd60000, 1'b1);         // interval across the wrap
    send(32'hFFFF_FFFF, IR_MAX, 1'b0);
    send(32'h0000_042C, IR_MAX, 1'b1);
    send(32'h0000_0558, IR_MAX, 1'b1);
    send(32'h0000_0684, IR_MAX, 1'b1);
    send(32'h0000_07B0, IR_MAX, 1'b1);
    now_ms       = 32'h0000_07B0;
    last_beat_ms = now_ms;
    run_random(RANDOM_PER_PHASE);
    settle();

    // everything counts as a finger, no alerts, pulse whenever average is nonzero
    load_settings('0, 8'd0, 8'd255, 8'd255, '0);
    send_idle_pct = 82;
    run_random(RANDOM_PER_PHASE);
    settle();

    // finger only at full scale, alert whenever the average is nonzero, holdoff at its maximum
    load_settings(IR_MAX, 8'd255, 8'd0, 8'd255, '1);
    send_idle_pct  = 0;
    recv_stall_pct = 82;
    run_random(RANDOM_PER_PHASE);
    settle();

    // mid-range settings, timestamps wrap during the phase
    load_settings(IR_W'($urandom_range(200000, 1000)), BPM_W'($urandom_range(80, 40)),
                  BPM_W'($urandom_range(150, 90)), BPM_W'($urandom_range(70, 30)),
                  $urandom_range(20000, 0));
    send_idle_pct  = 15;
    recv_stall_pct = 15;
    now_ms         = 32'hFFFF_8000;
    run_random(RANDOM_PER_PHASE);
    settle();

    // critical level at zero: no pulse can fire
    load_settings(IR_W'($urandom_range(100000, 0)), BPM_W'($urandom_range(255, 0)),
                  BPM_W'($urandom_range(255, 0)), 8'd0, $urandom());
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(RANDOM_PER_PHASE);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d samples under five register settings and four idle/stall mixes.",
             samples_sent);
    $display("Checked %0d result words: %0d rate alerts, %0d critical pulses.",
             checked, alerts, pulses);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
